[hdl/pci_pkg.sv]
// ----------------------------------------------------------------------------
// pci_pkg: shared types and constants for the palette color indexer
// Payload structs, chain token control, controller states, defaults.
// ----------------------------------------------------------------------------
package pci_pkg;

  localparam int unsigned MAX_COLORS_DEF = 224;
  localparam logic [7:0]  INDEX_OFFSET   = 8'd32;
  localparam logic [7:0]  LIMIT_RESET    = 8'd224;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] index_code;
    logic       new_color;
    logic       overflow_error;
    logic [7:0] colors_used;
  } out_res_t;

  // control part of the token that walks the cell chain
  typedef struct packed {
    logic valid;
    logic found;
    logic fresh;
  } tok_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } pci_state_t;

endpackage

[hdl/pci_cell.sv]
// ----------------------------------------------------------------------------
// pci_cell: one palette entry of the compare chain
// Holds one stored color, matches or appends the passing token, and hands
// the token to the next cell.
// ----------------------------------------------------------------------------
module pci_cell import pci_pkg::*; #(
  parameter int unsigned CNT_W = 8,
  parameter int unsigned K     = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [CNT_W-1:0] count,
  input  logic             room,
  input  tok_ctl_t         tok_in,
  input  logic [23:0]      color_in,
  input  logic [CNT_W-1:0] idx_in,
  output tok_ctl_t         tok_out,
  output logic [23:0]      color_out,
  output logic [CNT_W-1:0] idx_out
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(K);

  logic [23:0]      entry_r;
  tok_ctl_t         tok_r, tok_nxt;
  logic [23:0]      color_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             live, hit, app;

  assign live = tok_in.valid && !tok_in.found;
  // entries below the count were written this frame
  assign hit  = live && (MY_IDX < count) && (entry_r == color_in);
  assign app  = live && (MY_IDX == count) && room;

  always_comb begin
    tok_nxt = tok_in;
    idx_nxt = idx_in;
    if (hit || app) begin
      tok_nxt.found = 1'b1;
      idx_nxt       = MY_IDX;
    end
    if (app) begin
      tok_nxt.fresh = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      color_r <= color_in;
      idx_r   <= idx_nxt;
      if (app) begin
        entry_r <= color_in;
      end
    end
  end

  assign tok_out   = tok_r;
  assign color_out = color_r;
  assign idx_out   = idx_r;

endmodule

[hdl/palette_color_indexer.sv]
// ----------------------------------------------------------------------------
// palette_color_indexer: first-seen-order palette builder for RGB pixels
// Walks each pixel down a chain of entry cells and returns its palette code.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carries one pixel (frame_start plus RGB) per
//   transaction. out_valid/out_stall returns one result per pixel: index
//   plus 32 (0 on overflow), new-color flag, sticky overflow, entries used.
//   cfg_valid/cfg_ready writes color_limit; write only while idle.
// Timing:
//   A pixel travels one cell per cycle through MAX_COLORS cells while the
//   chain advances, the first cell loading at the accepting edge. The token
//   leaving the last cell loads the output register and raises out_valid.
//   One pixel is in the chain at a time; the next waits until it exits.
// Reset (rst_n low, synchronous): empty palette, overflow clear,
//   color_limit = 224, no result pending.
// Stall: a result waiting in the output register does not block the next
//   pixel; if a second result reaches the chain end before the first is
//   taken, the chain freezes until the output register frees up.
// ----------------------------------------------------------------------------
module palette_color_indexer import pci_pkg::*; #(
  parameter int unsigned MAX_COLORS = MAX_COLORS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_pix_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_res_t  out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_COLORS + 1);

  pci_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] count_cur;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       limit_r;
  logic [7:0]       lim_eff;
  logic             room;
  logic             accept, adv, tok_exit;
  logic             out_valid_r;
  out_res_t         out_data_r;

  tok_ctl_t         chain_tok [0:MAX_COLORS];
  logic [23:0]      chain_col [0:MAX_COLORS];
  logic [CNT_W-1:0] chain_idx [0:MAX_COLORS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  // cell 0 sees a frame-start pixel at the accepting edge: palette empty
  assign count_cur = (accept && in_data.frame_start) ? '0 : count_r;

  assign lim_eff = (limit_r > 8'(MAX_COLORS)) ? 8'(MAX_COLORS) : limit_r;
  assign room    = 8'(count_cur) < lim_eff;

  assign accept   = in_valid && !in_stall;
  assign adv      = !(chain_tok[MAX_COLORS].valid && out_valid_r && out_stall);
  assign tok_exit = chain_tok[MAX_COLORS].valid && adv;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept)   state_nxt = ST_WALK;
      ST_WALK: if (tok_exit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_WALK: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // token enters cell 0 on acceptance
  always_comb begin
    chain_tok[0]       = '0;
    chain_tok[0].valid = accept;
    chain_col[0]       = {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};
    chain_idx[0]       = '0;
  end

  for (genvar g = 0; g < MAX_COLORS; g++) begin : g_cell
    pci_cell #(
      .CNT_W (CNT_W),
      .K     (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .count     (count_cur),
      .room      (room),
      .tok_in    (chain_tok[g]),
      .color_in  (chain_col[g]),
      .idx_in    (chain_idx[g]),
      .tok_out   (chain_tok[g+1]),
      .color_out (chain_col[g+1]),
      .idx_out   (chain_idx[g+1])
    );
  end

  // count and sticky flag: cleared at frame start, updated when the token exits
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (accept && in_data.frame_start) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (tok_exit) begin
      if (chain_tok[MAX_COLORS].fresh) begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (!chain_tok[MAX_COLORS].found) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tok_exit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_exit) begin
      out_data_r.index_code     <= chain_tok[MAX_COLORS].found ?
                                   8'(chain_idx[MAX_COLORS]) + INDEX_OFFSET : 8'd0;
      out_data_r.new_color      <= chain_tok[MAX_COLORS].fresh;
      out_data_r.overflow_error <= ovf_nxt;
      out_data_r.colors_used    <= 8'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !chain_tok[MAX_COLORS].valid)
    else $error("token at chain end while idle");

  a_exit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    tok_exit |=> out_valid_r)
    else $error("exiting token did not load the output register");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    8'(count_r) <= 8'(MAX_COLORS))
    else $error("entry count above capacity");

  a_new_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.new_color) |-> (out_data_r.colors_used != 8'd0))
    else $error("new color reported with empty palette");

  a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_WALK))
    else $error("accepted pixel did not start a walk");
`endif

endmodule
